@@ rtl/core/bmp_row_pixel_unpacker_unit_assert.svh @@
// Assertion macros used by the scanline unpacker RTL.
`ifndef BMP_ROW_PIXEL_UNPACKER_UNIT_ASSERT_SVH
`define BMP_ROW_PIXEL_UNPACKER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BRPU_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication, disabled while reset is asserted.
`define BRPU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

@@ rtl/core/brpu_pkg.sv @@
package brpu_pkg;

    // Pixel layout of the scanline bytes.
    typedef enum logic [1:0] {
        FMT_BGRA32 = 2'd0,
        FMT_BGR24  = 2'd1,
        FMT_RGB565 = 2'd2,
        FMT_GREY8  = 2'd3
    } t_pix_fmt;

    // Request kinds on the input stream.
    typedef enum logic [0:0] {
        KIND_DATA    = 1'b0,
        KIND_PALETTE = 1'b1
    } t_kind;

    // Configuration register indexes.
    typedef enum logic [0:0] {
        REG_PIXEL_FORMAT = 1'b0,
        REG_ROW_WIDTH    = 1'b1
    } t_reg_idx;

    // Up to four 8-bit samples produced by one pixel.
    typedef logic [3:0][7:0] t_vals;

    localparam int unsigned CFG_DATA_W = 16;

    // RGB565 field masks.
    localparam logic [7:0] MASK_BLUE5   = 8'h1f;
    localparam logic [7:0] MASK_GREEN_L = 8'he0;
    localparam logic [7:0] MASK_GREEN_H = 8'h07;
    localparam logic [7:0] MASK_RED5    = 8'hf8;

    // Divide by three through a reciprocal: exact for sums up to 765.
    localparam logic [19:0] DIV3_MUL   = 20'd683;
    localparam int unsigned DIV3_SHIFT = 11;

endpackage

@@ rtl/core/bmp_row_pixel_unpacker_unit.sv @@
// BMP scanline pixel unpacker.
// Input stream (s_axis): one request per byte. tuser = 0 carries a scanline byte in
// tdata[7:0]; tuser = 1 writes palette entry tdata[15:8] with red, green, blue in
// tdata[23:16], tdata[31:24], tdata[39:32]. Palette writes and row padding bytes
// produce no output.
// Output stream (m_axis): one 16-bit sample per transfer, the 8-bit value repeated in
// both bytes. tuser[1:0] is the channel, tuser[2] marks the last sample of a pixel,
// tlast the last sample of a row. A 32-bit pixel gives 4 samples, 24-bit and RGB565
// give 3, a palette grey pixel 1.
// Configuration: i_cfg_we writes pixel_format (index 0) or row_width (index 1); only
// write while the block is idle.
// The last byte of a pixel loads the stage register, which passes the pixel on to the
// output register when it is free. One byte is accepted per cycle as long as the output
// serializer keeps up; it emits one sample per cycle while m_axis_tready is high, so with
// both registers full s_axis_tready stays low until the last sample of a pixel is taken.
// Reset is synchronous: the stream counters clear, pixel_format becomes 24-bit and
// row_width becomes 1. Palette contents are undefined until written.
// When the receiver stalls, the output register holds its sample and the stall
// backs up through the stage register to s_axis_tready.
module bmp_row_pixel_unpacker_unit #(
    parameter int PALETTE_ENTRIES = 256,
    parameter int WIDTH_BITS      = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // Configuration write port.
    input  logic                             i_cfg_we,
    input  logic [0:0]                       i_cfg_index,
    input  logic [brpu_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    // Input stream.
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // tdata: data_byte, pal_index, pal_red, pal_green, pal_blue (from bit 0 up).
    input  logic [39:0]                      s_axis_tdata,
    // tuser: kind.
    input  logic [0:0]                       s_axis_tuser,
    // Output stream.
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // tdata: sample.
    output logic [15:0]                      m_axis_tdata,
    // tuser: channel (2 bits), pixel_done (from bit 0 up).
    output logic [2:0]                       m_axis_tuser,
    output logic                             m_axis_tlast
);
    import brpu_pkg::*;

    localparam int PAL_AW = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;

    // Configuration registers.
    t_pix_fmt              r_fmt;
    logic [15:0]           r_row_width;

    // Stream state.
    logic [23:0]           r_held,  n_held;
    logic [1:0]            r_bip,   n_bip;
    logic [WIDTH_BITS-1:0] r_col,   n_col;
    logic [1:0]            r_pad,   n_pad;

    // Palette memory and its registered read port.
    logic [23:0]           r_pal_mem [PALETTE_ENTRIES];
    logic [23:0]           r_pal_q;
    logic                  r_pal_oor;

    // Stage register (pixel assembled) and output register (serializer).
    logic                  r_s1_valid;
    t_vals                 r_s1_vals;
    logic [1:0]            r_s1_last;
    logic                  r_s1_rd;
    logic                  r_s1_grey;

    logic                  r_s2_valid;
    t_vals                 r_s2_vals;
    logic [1:0]            r_s2_last;
    logic                  r_s2_rd;
    logic [1:0]            r_s2_idx;

    // Input field views.
    logic [7:0]            in_byte;
    logic [7:0]            in_pal_idx;
    logic [23:0]           in_pal_rgb;
    logic                  in_accept;
    logic                  in_is_data;

    // Pixel assembly signals.
    logic [1:0]            bpp_m1;
    logic [1:0]            bpp_mod4;
    logic [3:0]            pad_prod;
    logic [WIDTH_BITS-1:0] col_next;
    logic                  row_end;
    logic                  res_valid;
    t_vals                 res_vals;
    logic [1:0]            res_last;
    logic                  res_grey;

    // Grey conversion and pipeline control.
    logic [9:0]            grey_sum;
    logic [19:0]           grey_prod;
    logic [7:0]            grey_val;
    logic                  s2_done;
    logic                  s2_load;
    logic                  s1_adv;

    assign in_byte    = s_axis_tdata[7:0];
    assign in_pal_idx = s_axis_tdata[15:8];
    assign in_pal_rgb = {s_axis_tdata[23:16], s_axis_tdata[31:24], s_axis_tdata[39:32]};
    assign in_accept  = s_axis_tvalid && s_axis_tready;
    assign in_is_data = (t_kind'(s_axis_tuser) == KIND_DATA);

    // Pipeline handshake: the output register reloads when empty or when its last sample is taken.
    assign s2_done       = r_s2_valid && m_axis_tready && (r_s2_idx == r_s2_last);
    assign s2_load       = !r_s2_valid || s2_done;
    assign s1_adv        = r_s1_valid && s2_load;
    assign s_axis_tready = !r_s1_valid || s2_load;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fmt       <= FMT_BGR24;
            r_row_width <= 16'd1;
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_index))
                REG_PIXEL_FORMAT: r_fmt       <= t_pix_fmt'(i_cfg_data[1:0]);
                REG_ROW_WIDTH:    r_row_width <= i_cfg_data;
                default:          r_row_width <= r_row_width;
            endcase
        end
    end

    // Bytes per pixel, less one, and modulo four for the row padding.
    always_comb begin
        case (r_fmt)
            FMT_BGRA32: begin bpp_m1 = 2'd3; bpp_mod4 = 2'd0; end
            FMT_BGR24:  begin bpp_m1 = 2'd2; bpp_mod4 = 2'd3; end
            FMT_RGB565: begin bpp_m1 = 2'd1; bpp_mod4 = 2'd2; end
            default:    begin bpp_m1 = 2'd0; bpp_mod4 = 2'd1; end
        endcase
    end

    assign pad_prod = {2'd0, bpp_mod4} * {2'd0, r_row_width[1:0]};
    assign col_next = r_col + WIDTH_BITS'(1);
    assign row_end  = (col_next == WIDTH_BITS'(r_row_width));

    // Byte collection, pixel completion and row padding.
    always_comb begin
        n_held    = r_held;
        n_bip     = r_bip;
        n_col     = r_col;
        n_pad     = r_pad;
        res_valid = 1'b0;
        res_vals  = '0;
        res_last  = 2'd0;
        res_grey  = 1'b0;
        if (in_accept && in_is_data) begin
            if (r_pad != 2'd0) begin
                n_pad = r_pad - 2'd1;
            end else if (r_bip < bpp_m1) begin
                case (r_bip)
                    2'd0:    n_held = r_held | {16'd0, in_byte};
                    2'd1:    n_held = r_held | {8'd0, in_byte, 8'd0};
                    default: n_held = r_held | {in_byte, 16'd0};
                endcase
                n_bip = r_bip + 2'd1;
            end else begin
                res_valid = 1'b1;
                case (r_fmt)
                    FMT_BGRA32: begin
                        res_vals = {in_byte, r_held[7:0], r_held[15:8], r_held[23:16]};
                        res_last = 2'd3;
                    end
                    FMT_BGR24: begin
                        res_vals = {8'd0, r_held[7:0], r_held[15:8], in_byte};
                        res_last = 2'd2;
                    end
                    FMT_RGB565: begin
                        res_vals[0] = in_byte & MASK_RED5;
                        res_vals[1] = {(in_byte & MASK_GREEN_H) << 5}
                                    | {(r_held[7:0] & MASK_GREEN_L) >> 3};
                        res_vals[2] = {r_held[4:0] & MASK_BLUE5[4:0], 3'd0};
                        res_last    = 2'd2;
                    end
                    default: begin
                        res_grey = 1'b1;
                        res_last = 2'd0;
                    end
                endcase
                n_held = '0;
                n_bip  = 2'd0;
                if (row_end) begin
                    n_col = '0;
                    n_pad = 2'(2'd0 - pad_prod[1:0]);
                end else begin
                    n_col = col_next;
                end
            end
        end
    end

    // Stream state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held <= '0;
            r_bip  <= 2'd0;
            r_col  <= '0;
            r_pad  <= 2'd0;
        end else begin
            r_held <= n_held;
            r_bip  <= n_bip;
            r_col  <= n_col;
            r_pad  <= n_pad;
        end
    end

    // Palette memory: written by palette requests, read on every accepted data byte.
    always_ff @(posedge i_clk) begin
        if (in_accept && !in_is_data && ({1'b0, in_pal_idx} < 9'(PALETTE_ENTRIES))) begin
            r_pal_mem[in_pal_idx[PAL_AW-1:0]] <= in_pal_rgb;
        end
        if (in_accept && in_is_data) begin
            r_pal_q   <= r_pal_mem[in_byte[PAL_AW-1:0]];
            r_pal_oor <= ({1'b0, in_byte} >= 9'(PALETTE_ENTRIES));
        end
    end

    // Stage register: holds a finished pixel until the output register is free.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_s1_valid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && res_valid) begin
            r_s1_vals <= res_vals;
            r_s1_last <= res_last;
            r_s1_rd   <= row_end;
            r_s1_grey <= res_grey;
        end
    end

    // Grey level: average of the palette components, inverted.
    assign grey_sum  = r_pal_oor ? 10'd0
                     : ({2'd0, r_pal_q[23:16]} + {2'd0, r_pal_q[15:8]} + {2'd0, r_pal_q[7:0]});
    assign grey_prod = {10'd0, grey_sum} * DIV3_MUL;
    assign grey_val  = ~grey_prod[DIV3_SHIFT+7:DIV3_SHIFT];

    // Output register and sample serializer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
            r_s2_idx   <= 2'd0;
        end else if (s2_load) begin
            r_s2_valid <= r_s1_valid;
            r_s2_idx   <= 2'd0;
        end else if (m_axis_tready) begin
            r_s2_idx   <= r_s2_idx + 2'd1;
        end
    end

    // A grey pixel takes its single value from the palette read.
    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_s2_vals <= r_s1_grey ? {r_s1_vals[3:1], grey_val} : r_s1_vals;
            r_s2_last <= r_s1_last;
            r_s2_rd   <= r_s1_rd;
        end
    end

    // Output ports.
    assign m_axis_tvalid = r_s2_valid;
    assign m_axis_tdata  = {r_s2_vals[r_s2_idx], r_s2_vals[r_s2_idx]};
    assign m_axis_tuser  = {(r_s2_idx == r_s2_last), r_s2_idx};
    assign m_axis_tlast  = (r_s2_idx == r_s2_last) && r_s2_rd;

    // Checks.
`include "bmp_row_pixel_unpacker_unit_assert.svh"

    `BRPU_ASSERT_IMPL(a_idx_in_range, i_clk, i_rst_n, r_s2_valid, r_s2_idx <= r_s2_last)
    `BRPU_ASSERT_NEXT(a_s1_held, i_clk, i_rst_n, r_s1_valid && !s2_load, r_s1_valid)
    `BRPU_ASSERT_IMPL(a_pad_at_row_start, i_clk, i_rst_n, r_pad != 2'd0,
                      (r_bip == 2'd0) && (r_col == '0))
    `BRPU_ASSERT_IMPL(a_grey_single, i_clk, i_rst_n, r_s1_valid && r_s1_grey,
                      r_s1_last == 2'd0)

endmodule
